@@ rtl/core/lzss_ring_decompressor_top_macros.svh @@
// Assertion macros used by the checker file.
`ifndef LZSS_RING_DECOMPRESSOR_TOP_MACROS_SVH
`define LZSS_RING_DECOMPRESSOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LZSS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LZSS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/lzss_pkg.sv @@
`default_nettype none

package lzss_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam logic [RING_AW-1:0] RING_START = RING_AW'(4078);
  localparam logic [RING_AW:0]   FILL_MAX   = (RING_AW+1)'(RING_DEPTH);

  localparam int LEN_W    = 5;
  localparam int LEN_BIAS = 3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STRICT_CHECK  = CFG_IDX_W'(1);

  // Token phase codes.
  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_MLO  = 2'd2;
  localparam logic [1:0] PH_MHI  = 2'd3;

  typedef struct packed {
    logic load_in;
    logic token_step;
    logic emit_status;
    logic emit_lit;
    logic start_match;
    logic emit_copy;
    logic copy_next;
    logic end_tok;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       active;
    logic       ilast;
    logic       obuf_free;
    logic       copy_done;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/lzss_ram.sv @@
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lzss_ctrl.sv @@
`default_nettype none

module lzss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lzss_pkg::sts_t sts,
  output lzss_pkg::cmd_t      cmd
);
  import lzss_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_COPY   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.active || sts.phase == PH_FLAG || sts.phase == PH_MLO) begin
          if (!sts.ilast) begin
            cmd.token_step = 1'b1;
            state_next     = S_IDLE;
          end else if (sts.obuf_free) begin
            cmd.emit_status = 1'b1;
            cmd.clear       = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (sts.phase == PH_LIT) begin
          if (sts.obuf_free) begin
            cmd.emit_lit = 1'b1;
            cmd.clear    = sts.ilast;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.start_match = 1'b1;
          state_next      = S_COPY;
        end
      end
      S_COPY: begin
        if (sts.obuf_free) begin
          cmd.emit_copy = 1'b1;
          if (sts.copy_done) begin
            cmd.end_tok = 1'b1;
            cmd.clear   = sts.ilast;
            state_next  = S_IDLE;
          end else begin
            cmd.copy_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lzss_dp.sv @@
`default_nettype none

module lzss_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lzss_pkg::cmd_t                 cmd,
  output lzss_pkg::sts_t                      sts,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_last,
  input  wire logic                           cfg_valid,
  input  wire logic [lzss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [7:0]                     out_byte,
  output logic                                byte_valid,
  output logic                                run_last,
  output logic                                stream_end,
  output logic                                size_mismatch
);
  import lzss_pkg::*;

  logic [31:0]        expected_size;
  logic               strict_check;
  logic [7:0]         ibyte;
  logic               ilast;
  logic [8:0]         flag_shift;
  logic [1:0]         phase;
  logic [7:0]         mlo;
  logic [RING_AW-1:0] wp;
  logic [RING_AW:0]   fill;
  logic [31:0]        count;
  logic [RING_AW-1:0] rptr;
  logic [LEN_W-1:0]   rem;
  logic               byp;
  logic [7:0]         byp_data;
  logic               zero_rd;

  logic [31:0]        count_inc;
  logic               active;
  logic               size_hit;
  logic               copy_done;
  logic [7:0]         rd_data;
  logic [7:0]         pending;
  logic [RING_AW-1:0] src;
  logic [LEN_W-1:0]   len;
  logic               we;
  logic [7:0]         wdata;
  logic [RING_AW:0]   fill_next;
  logic               re;
  logic [RING_AW-1:0] raddr;
  logic [RING_AW-1:0] roff;
  logic               rd_ok;
  logic [8:0]         shifted;
  logic [1:0]         end_phase;
  logic               obuf_free;

  always_comb begin
    count_inc = count + 32'd1;
    active    = count < expected_size;
    size_hit  = count_inc >= expected_size;
    copy_done = (rem == LEN_W'(1)) || size_hit;
    pending   = zero_rd ? 8'd0 : (byp ? byp_data : rd_data);
    src       = {ibyte[7:4], mlo};
    len       = {1'b0, ibyte[3:0]} + LEN_W'(LEN_BIAS);
    we        = cmd.emit_lit | cmd.emit_copy;
    wdata     = cmd.emit_lit ? ibyte : pending;
    fill_next = (we && fill != FILL_MAX) ? fill + (RING_AW+1)'(1) : fill;
    re        = cmd.start_match | cmd.copy_next;
    raddr     = cmd.start_match ? src : rptr;
    // An entry counts as written when it lies within the span filled since stream start.
    roff      = raddr - RING_START;
    rd_ok     = {1'b0, roff} < fill_next;
    shifted   = flag_shift >> 1;
    if (shifted <= 9'd1) begin
      end_phase = PH_FLAG;
    end else begin
      end_phase = shifted[0] ? PH_LIT : PH_MLO;
    end
    obuf_free = !out_valid || out_ready;

    sts.phase     = phase;
    sts.active    = active;
    sts.ilast     = ilast;
    sts.obuf_free = obuf_free;
    sts.copy_done = copy_done;
  end

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ibyte <= in_byte;
      ilast <= in_last;
    end
    if (re) begin
      rptr     <= raddr + RING_AW'(1);
      byp      <= we && (raddr == wp);
      byp_data <= wdata;
      zero_rd  <= !rd_ok;
    end
    if (cmd.start_match) begin
      rem <= len;
    end else if (cmd.emit_copy) begin
      rem <= rem - LEN_W'(1);
    end
    if (cmd.emit_status) begin
      out_byte      <= 8'd0;
      byte_valid    <= 1'b0;
      run_last      <= 1'b1;
      stream_end    <= 1'b1;
      size_mismatch <= strict_check && (count != expected_size);
    end else if (cmd.emit_lit) begin
      out_byte      <= ibyte;
      byte_valid    <= 1'b1;
      run_last      <= 1'b1;
      stream_end    <= size_hit || ilast;
      size_mismatch <= ilast && strict_check && (count_inc != expected_size);
    end else if (cmd.emit_copy) begin
      out_byte      <= pending;
      byte_valid    <= 1'b1;
      run_last      <= copy_done;
      stream_end    <= size_hit || (ilast && copy_done);
      size_mismatch <= ilast && copy_done && strict_check && (count_inc != expected_size);
    end
  end

  // Control and stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= 32'd0;
      strict_check  <= 1'b0;
      flag_shift    <= 9'd0;
      phase         <= PH_FLAG;
      mlo           <= 8'd0;
      wp            <= RING_START;
      fill          <= '0;
      count         <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_EXPECTED_SIZE: expected_size <= cfg_data;
          REG_STRICT_CHECK:  strict_check  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.token_step && active) begin
        case (phase)
          PH_FLAG: begin
            flag_shift <= {1'b1, ibyte};
            phase      <= ibyte[0] ? PH_LIT : PH_MLO;
          end
          PH_MLO: begin
            mlo   <= ibyte;
            phase <= PH_MHI;
          end
          default: ;
        endcase
      end
      if (cmd.emit_lit || cmd.end_tok) begin
        flag_shift <= shifted;
        phase      <= end_phase;
      end
      if (we) begin
        wp    <= wp + RING_AW'(1);
        fill  <= fill_next;
        count <= count_inc;
      end
      if (cmd.emit_status || cmd.emit_lit || cmd.emit_copy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        flag_shift <= 9'd0;
        phase      <= PH_FLAG;
        mlo        <= 8'd0;
        wp         <= RING_START;
        fill       <= '0;
        count      <= 32'd0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lzss_ring_decompressor_top.sv @@
// LZSS decoder with a 4096-byte history ring.
// Input channel (in_valid/in_ready): one compressed byte per beat, in_last on the
// final byte of a stream. Output channel (out_valid/out_ready): one result per beat,
// a decoded byte (byte_valid = 1) or a status-only result at the end of a stream.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets expected_size,
// index 1 sets strict_check. Write it only while the block is idle.
// Sequence: an input beat is taken in the idle state and decoded in the decode state.
// Flag and match-low bytes update the token state, a literal emits its byte, and a
// match enters the copy state and emits its copied bytes in turn: the ring is read
// once per copied byte through its single registered read port, with a bypass for
// back-to-back overlapping copies.
// A one-entry output register holds each result; a new input beat is taken while
// it waits. When the receiver stalls, each step that emits a result holds until
// the register drains. Reset clears all stream state and zeroes both config registers;
// the final byte of a stream does the same to the stream state. The ring itself is
// never swept: a fill count marks which entries this stream wrote, others read 0.
`default_nettype none

module lzss_ring_decompressor_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_last,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [7:0]                     out_byte,
  output logic                                byte_valid,
  output logic                                run_last,
  output logic                                stream_end,
  output logic                                size_mismatch,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lzss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import lzss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Config writes are always accepted.
  assign cfg_ready = 1'b1;

  // Sequence the tokens: take a beat, decode it, walk a match.
  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold ring, token state, counters and the output register.
  lzss_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .run_last      (run_last),
    .stream_end    (stream_end),
    .size_mismatch (size_mismatch)
  );

endmodule

`default_nettype wire

@@ rtl/core/lzss_chk.sv @@
`default_nettype none

`include "lzss_ring_decompressor_top_macros.svh"

module lzss_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       run_last,
  input wire logic       stream_end,
  input wire logic       size_mismatch
);

  // A stalled result holds.
  `LZSS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte))

  // A status-only result closes both the beat and the stream.
  `LZSS_ASSERT_IMP(a_status_end, clk, rst, out_valid && !byte_valid, run_last && stream_end)

  // A mismatch flag only rides on the closing result of a stream.
  `LZSS_ASSERT_IMP(a_mis_end, clk, rst, out_valid && size_mismatch, run_last && stream_end)

  // After taking a beat, decode before taking another.
  `LZSS_ASSERT_NXT(a_in_gap, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind lzss_ring_decompressor_top lzss_chk u_chk (.*);

`default_nettype wire

@@ dv/lzss_ring_decompressor_top_tb.sv @@
`timescale 1ns / 1ps

module lzss_ring_decompressor_top_tb;
  import lzss_pkg::*;

  localparam int ITEMS_TARGET = 430;
  localparam int DRAIN_CYCLES = 32;       // longest match plus pipeline slack
  localparam int HOLD_OFF     = 400;
  localparam int CYCLE_LIMIT  = 500000;

  // One decoded result as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       beat_last;
    logic       end_flag;
    logic       mismatch;
  } dec_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic [7:0]           in_byte   = 8'h00;
  logic                 in_last   = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  wire logic            in_ready;
  wire logic            out_valid;
  wire logic [7:0]      out_byte;
  wire logic            byte_valid;
  wire logic            run_last;
  wire logic            stream_end;
  wire logic            size_mismatch;
  wire logic            cfg_ready;

  lzss_ring_decompressor_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .run_last      (run_last),
    .stream_end    (stream_end),
    .size_mismatch (size_mismatch),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder image kept by the bench: history, pointers and registers.
  logic [7:0]  hist [RING_DEPTH];
  logic [11:0] wr_pos;
  logic [8:0]  flags;
  logic [1:0]  phase;
  logic [7:0]  lo_byte;
  logic [31:0] out_count;
  logic [31:0] size_limit;
  logic        strict_mode;

  dec_result_t step_out[$];         // results of the beat being decoded
  dec_result_t pending_results[$];  // results still owed by the block

  bit idle_on     = 1'b1;
  int hold_cycles = 0;
  int cycle_count = 0;
  int mismatches  = 0;
  int items_sent  = 0;

  function automatic void clear_stream();
    foreach (hist[i]) hist[i] = 8'h00;
    wr_pos    = RING_START;
    flags     = '0;
    phase     = PH_FLAG;
    lo_byte   = '0;
    out_count = '0;
  endfunction

  function automatic void next_phase();
    if (flags <= 9'd1) phase = PH_FLAG;
    else phase = flags[0] ? PH_LIT : PH_MLO;
  endfunction

  // Emit one decoded byte and write it back into the history.
  function automatic void put_decoded(input logic [7:0] v);
    dec_result_t r;
    hist[wr_pos] = v;
    wr_pos = wr_pos + 12'd1;
    out_count = out_count + 32'd1;
    r = '0;
    r.data = v;
    r.has_data = 1'b1;
    r.end_flag = (out_count >= size_limit);
    step_out = {step_out, r};
  endfunction

  // Decode one accepted beat and queue every result it owes.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [11:0] src;
    int          len;
    dec_result_t r;
    step_out.delete();
    if (out_count < size_limit) begin
      case (phase)
        PH_FLAG: begin
          flags = {1'b1, b};
          next_phase();
        end
        PH_LIT: begin
          put_decoded(b);
          flags = flags >> 1;
          next_phase();
        end
        PH_MLO: begin
          lo_byte = b;
          phase = PH_MHI;
        end
        default: begin
          src = {b[7:4], lo_byte};
          len = int'(b[3:0]) + LEN_BIAS;
          // Copy one byte at a time so overlapping copies repeat data.
          for (int i = 0; i < len && out_count < size_limit; i++) begin
            put_decoded(hist[src]);
            src = src + 12'd1;
          end
          flags = flags >> 1;
          next_phase();
        end
      endcase
    end
    if (last) begin
      if (step_out.size() == 0) begin
        r = '0;
        step_out = {step_out, r};
      end
      r = step_out[step_out.size() - 1];
      r.end_flag = 1'b1;
      r.mismatch = strict_mode && (out_count != size_limit);
      step_out[step_out.size() - 1] = r;
      clear_stream();
    end
    if (step_out.size() > 0) begin
      r = step_out[step_out.size() - 1];
      r.beat_last = 1'b1;
      step_out[step_out.size() - 1] = r;
    end
    pending_results = {pending_results, step_out};
  endfunction

  // Offer one compressed byte, hold it until taken, then predict.
  task automatic send_beat(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    decode_byte(b, last);
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high across the two beats.
  task automatic write_regs(input logic [31:0] size, input logic [31:0] strict_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_EXPECTED_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_limit = size;
    cfg_index <= REG_STRICT_CHECK;
    cfg_data  <= strict_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    strict_mode = strict_word[0];
    cfg_valid <= 1'b0;
  endtask

  // Build a stream that follows the token phase, with some noise mixed in.
  // Match sources mostly point a short way back so copies return real data.
  task automatic run_stream(input int n_bytes, input int noise_pct);
    logic [7:0]  b;
    logic [11:0] src;
    logic [3:0]  src_hi;
    src_hi = '0;
    for (int k = 0; k < n_bytes; k++) begin
      b = 8'($urandom);
      if ($urandom_range(0, 99) >= noise_pct) begin
        case (phase)
          PH_MLO: begin
            if ($urandom_range(0, 3) != 0) src = wr_pos - 12'($urandom_range(1, 24));
            else src = 12'($urandom);
            src_hi = src[11:8];
            b = src[7:0];
          end
          PH_MHI: b = {src_hi, ($urandom_range(0, 9) < 3) ? 4'hF : 4'($urandom)};
          default: ;
        endcase
      end
      send_beat(b, k == n_bytes - 1);
    end
  endtask

  task automatic random_stream();
    int          pick;
    int          n;
    logic [31:0] size;
    logic [31:0] strict_word;
    pick = $urandom_range(0, 99);
    if (pick < 55) size = '1;
    else if (pick < 80) size = $urandom_range(1, 80);
    else if (pick < 88) size = '0;
    else size = $urandom;
    if ($urandom_range(0, 3) == 0) strict_word = $urandom;
    else strict_word = {31'd0, 1'($urandom)};
    pick = $urandom_range(0, 99);
    if (size == 0) n = $urandom_range(1, 3);
    else if (pick < 10) n = $urandom_range(1, 2);
    else if (pick < 90) n = $urandom_range(4, 40);
    else n = $urandom_range(60, 120);
    drain();
    write_regs(size, strict_word);
    run_stream(n, 10);
  endtask

  // Literals at both byte extremes, an overlapping longest match, a match over
  // history written after the ring wrapped, and a stream cut off after a match low byte.
  task automatic test_basic_tokens();
    drain();
    write_regs('1, 32'd0);
    send_beat(8'h03, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hEE, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h34, 1'b1);
  endtask

  // Size reached inside a match: the copy stops early, later bytes are
  // swallowed, and the final byte gives a clean status.
  task automatic test_size_reached();
    drain();
    write_regs(32'd5, 32'd1);
    send_beat(8'h01, 1'b0);
    send_beat(8'hAA, 1'b0);
    send_beat(8'hEE, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'h77, 1'b1);
  endtask

  // Zero expected size: every byte is ignored from the start.
  task automatic test_zero_size();
    drain();
    write_regs(32'd0, 32'd1);
    send_beat(8'h80, 1'b0);
    send_beat(8'hFF, 1'b1);
  endtask

  // Strict shortfall on a literal, on a match and on a lone flag byte.
  task automatic test_short_stream_strict();
    drain();
    write_regs('1, 32'd1);
    send_beat(8'h01, 1'b0);
    send_beat(8'h5A, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hEE, 1'b0);
    send_beat(8'h12, 1'b1);
    send_beat(8'hC3, 1'b1);
  endtask

  task automatic test_random_streams(input int target);
    while (items_sent < target) random_stream();
  endtask

  // No idling on either side for one long stream.
  task automatic test_burst();
    drain();
    idle_on = 1'b0;
    write_regs('1, 32'd0);
    run_stream(80, 5);
    drain();
    idle_on = 1'b1;
  endtask

  // Hold the receiver off while bytes keep coming, so the input stalls.
  task automatic test_backpressure();
    drain();
    write_regs('1, 32'd1);
    hold_cycles = HOLD_OFF;
    run_stream(40, 0);
  endtask

  // Receiver: random stalls, a long hold-off on request, none during a burst.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 32);
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    dec_result_t want;
    dec_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = {out_byte, byte_valid, run_last, stream_end, size_mismatch};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at %0t: byte %02h valid %b last %b end %b size %b",
                   $time, got.data, got.has_data, got.beat_last, got.end_flag,
                   got.mismatch);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: expected byte %02h valid %b last %b end %b size %b,",
                      " got byte %02h valid %b last %b end %b size %b"},
                     $time, want.data, want.has_data, want.beat_last, want.end_flag,
                     want.mismatch, got.data, got.has_data, got.beat_last,
                     got.end_flag, got.mismatch);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_stream();
    size_limit  = '0;
    strict_mode = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_tokens();
    test_size_reached();
    test_zero_size();
    test_short_stream_strict();
    test_random_streams(200);
    test_burst();
    test_backpressure();
    test_random_streams(ITEMS_TARGET);
    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
